FILE: rtl/tesp_pkg.sv
package tesp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDLE   = 3'd1,
        PH_EVENT  = 3'd2,
        PH_FIXED  = 3'd3,
        PH_LENGTH = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        K_ERROR = 3'd0,
        K_CHUNK = 3'd1,
        K_BYTE  = 3'd2,
        K_WORD  = 3'd3,
        K_DWORD = 3'd4,
        K_TEXT  = 3'd5
    } t_kind;

    localparam logic [7:0] MAGIC [4] = '{8'h46, 8'h4C, 8'h68, 8'h64};

    // header layout: 4 magic + 10 rest + 4 data tag, then 4 length bytes
    localparam logic [4:0] HDR_MAGIC_END = 5'd4;
    localparam logic [4:0] HDR_LEN_START = 5'd18;
    localparam logic [4:0] HDR_LEN_END   = 5'd22;

    localparam logic [7:0] ID_WORD_MIN  = 8'd64;
    localparam logic [7:0] ID_DWORD_MIN = 8'd128;
    localparam logic [7:0] ID_TEXT_MIN  = 8'd192;

    localparam logic [5:0] LEB_SHIFT_LIMIT = 6'd32;
    localparam logic [5:0] LEB_SHIFT_STEP  = 6'd7;

    function automatic t_kind fixed_kind(input logic [7:0] id);
        t_kind k;
        if (id < ID_WORD_MIN) begin
            k = K_BYTE;
        end else if (id < ID_DWORD_MIN) begin
            k = K_WORD;
        end else begin
            k = K_DWORD;
        end
        return k;
    endfunction

endpackage

FILE: rtl/tesp_byte_if.sv
interface tesp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

FILE: rtl/tesp_res_if.sv
interface tesp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  event_id;
    logic [31:0] value;

    modport source (output valid, output kind, output event_id, output value, input ready);
    modport sink   (input valid, input kind, input event_id, input value, output ready);
endinterface

FILE: rtl/tagged_event_stream_parser.sv
// Byte-stream parser for tagged event files: checks the 'FLhd' magic, reports the
// little-endian chunk length, then one result per fixed-size event (byte, word,
// dword) and per LEB128-length text event, skipping text payloads. A header
// mismatch gives one error result and silence until a byte marked first_byte.
// One valid byte is taken every cycle unless the input is stalled; the state update
// and the result register sit behind a single level of logic, so a result appears in
// the cycle after the byte that completes it. The input stalls only while the result
// register holds an unconsumed result and the sink is not ready.
module tagged_event_stream_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tesp_byte_if.sink     i_in,
    tesp_res_if.source    o_res
);

    tesp_pkg::t_phase r_phase, c_phase, n_phase;
    logic [4:0]       r_byte_count, c_byte_count, n_byte_count;
    logic [7:0]       r_current_id, c_current_id, n_current_id;
    logic [31:0]      r_accumulator, c_accumulator, n_accumulator;
    logic [2:0]       r_bytes_left, c_bytes_left, n_bytes_left;
    logic [5:0]       r_length_shift, c_length_shift, n_length_shift;
    logic [31:0]      r_skip_count, c_skip_count, n_skip_count;

    logic             r_out_valid;
    tesp_pkg::t_kind  r_out_kind, n_out_kind;
    logic [7:0]       r_out_id, n_out_id;
    logic [31:0]      r_out_value, n_out_value;
    logic             n_emit;

    logic             in_accept;
    logic [7:0]       b;
    logic [4:0]       hdr_off;

    assign b         = i_in.data_byte;
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign in_accept = i_in.valid && i_in.ready;
    assign hdr_off   = c_byte_count - tesp_pkg::HDR_LEN_START;

    always_comb begin
        if (i_in.first_byte) begin
            c_phase        = tesp_pkg::PH_HEADER;
            c_byte_count   = '0;
            c_current_id   = '0;
            c_accumulator  = '0;
            c_bytes_left   = '0;
            c_length_shift = '0;
            c_skip_count   = '0;
        end else begin
            c_phase        = r_phase;
            c_byte_count   = r_byte_count;
            c_current_id   = r_current_id;
            c_accumulator  = r_accumulator;
            c_bytes_left   = r_bytes_left;
            c_length_shift = r_length_shift;
            c_skip_count   = r_skip_count;
        end

        n_phase        = c_phase;
        n_byte_count   = c_byte_count;
        n_current_id   = c_current_id;
        n_accumulator  = c_accumulator;
        n_bytes_left   = c_bytes_left;
        n_length_shift = c_length_shift;
        n_skip_count   = c_skip_count;
        n_emit         = 1'b0;
        n_out_kind     = tesp_pkg::K_ERROR;
        n_out_id       = '0;
        n_out_value    = '0;

        unique case (c_phase)
            tesp_pkg::PH_HEADER: begin
                if (c_byte_count < tesp_pkg::HDR_MAGIC_END) begin
                    if (b != tesp_pkg::MAGIC[c_byte_count[1:0]]) begin
                        n_phase    = tesp_pkg::PH_IDLE;
                        n_emit     = 1'b1;
                        n_out_kind = tesp_pkg::K_ERROR;
                    end else begin
                        n_byte_count = c_byte_count + 5'd1;
                    end
                end else if (c_byte_count < tesp_pkg::HDR_LEN_START) begin
                    n_byte_count = c_byte_count + 5'd1;
                end else begin
                    n_accumulator = c_accumulator | ({24'd0, b} << {hdr_off[1:0], 3'b000});
                    n_byte_count  = c_byte_count + 5'd1;
                    if (n_byte_count >= tesp_pkg::HDR_LEN_END) begin
                        n_emit        = 1'b1;
                        n_out_kind    = tesp_pkg::K_CHUNK;
                        n_out_value   = n_accumulator;
                        n_accumulator = '0;
                        n_byte_count  = '0;
                        n_phase       = tesp_pkg::PH_EVENT;
                    end
                end
            end
            tesp_pkg::PH_IDLE: begin
            end
            tesp_pkg::PH_EVENT: begin
                n_current_id   = b;
                n_accumulator  = '0;
                n_length_shift = '0;
                n_phase        = tesp_pkg::PH_FIXED;
                if (b < tesp_pkg::ID_WORD_MIN) begin
                    n_bytes_left = 3'd1;
                end else if (b < tesp_pkg::ID_DWORD_MIN) begin
                    n_bytes_left = 3'd2;
                end else if (b < tesp_pkg::ID_TEXT_MIN) begin
                    n_bytes_left = 3'd4;
                end else begin
                    n_phase = tesp_pkg::PH_LENGTH;
                end
            end
            tesp_pkg::PH_FIXED: begin
                n_accumulator  = c_accumulator
                               | ({24'd0, b} << {c_length_shift[4:3], 3'b000});
                n_length_shift = c_length_shift + 6'd8;
                n_bytes_left   = c_bytes_left - 3'd1;
                if (n_bytes_left == 3'd0) begin
                    n_phase     = tesp_pkg::PH_EVENT;
                    n_emit      = 1'b1;
                    n_out_kind  = tesp_pkg::fixed_kind(c_current_id);
                    n_out_id    = c_current_id;
                    n_out_value = n_accumulator;
                end
            end
            tesp_pkg::PH_LENGTH: begin
                if (c_length_shift < tesp_pkg::LEB_SHIFT_LIMIT) begin
                    n_accumulator  = c_accumulator
                                   | ({25'd0, b[6:0]} << c_length_shift[4:0]);
                    n_length_shift = c_length_shift + tesp_pkg::LEB_SHIFT_STEP;
                end
                if (!b[7]) begin
                    n_skip_count = n_accumulator;
                    n_phase      = (n_accumulator == '0) ? tesp_pkg::PH_EVENT
                                                         : tesp_pkg::PH_SKIP;
                    n_emit       = 1'b1;
                    n_out_kind   = tesp_pkg::K_TEXT;
                    n_out_id     = c_current_id;
                    n_out_value  = n_accumulator;
                end
            end
            tesp_pkg::PH_SKIP: begin
                n_skip_count = c_skip_count - 32'd1;
                if (n_skip_count == '0) begin
                    n_phase = tesp_pkg::PH_EVENT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tesp_pkg::PH_HEADER;
            r_byte_count   <= '0;
            r_current_id   <= '0;
            r_accumulator  <= '0;
            r_bytes_left   <= '0;
            r_length_shift <= '0;
            r_skip_count   <= '0;
        end else if (in_accept) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_current_id   <= n_current_id;
            r_accumulator  <= n_accumulator;
            r_bytes_left   <= n_bytes_left;
            r_length_shift <= n_length_shift;
            r_skip_count   <= n_skip_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= in_accept && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out_kind  <= n_out_kind;
            r_out_id    <= n_out_id;
            r_out_value <= n_out_value;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.kind     = r_out_kind;
    assign o_res.event_id = r_out_id;
    assign o_res.value    = r_out_value;

    // skip phase always has payload bytes outstanding
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tesp_pkg::PH_SKIP |-> r_skip_count != '0)
        else $error("skip phase with zero count");

    a_fixed_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tesp_pkg::PH_FIXED |-> (r_bytes_left != 3'd0 && r_bytes_left <= 3'd4))
        else $error("fixed event byte count out of range");

    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_emit && n_out_kind == tesp_pkg::K_ERROR |=> r_phase == tesp_pkg::PH_IDLE)
        else $error("header error did not stop the parser");

    a_header_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == tesp_pkg::K_ERROR || r_out_kind == tesp_pkg::K_CHUNK)
        |-> r_out_id == '0)
        else $error("header result with nonzero event id");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");

endmodule
